@@ hw/rtl/lse_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types and constants of the LSB stego stream extractor.
// ----------------------------------------------------------------------------
package lse_pkg;

  // Frame geometry
  localparam int SIZE_FIELD_BITS = 32;
  localparam int CHAR_BITS       = 8;
  localparam int MAX_EXTN_CHARS  = 4;
  localparam int MAX_MAGIC_CHARS = 8;

  // Counter and field widths
  localparam int BitCntW = $clog2(SIZE_FIELD_BITS + 1);

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_HEADER_SKIP   = 3'd0,
    CFG_MAGIC_LENGTH  = 3'd1,
    CFG_MAGIC_CHARS   = 3'd2,
    CFG_EXTN_CHECK_EN = 3'd3,
    CFG_EXP_EXTN_LEN  = 3'd4,
    CFG_EXP_EXTN      = 3'd5
  } cfg_idx_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_EXTN_CHAR = 2'd0,
    KIND_PAYLOAD   = 2'd1,
    KIND_EMPTY     = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_e;

  // Error codes
  typedef enum logic [1:0] {
    ERR_MAGIC      = 2'd0,
    ERR_EXTN_LONG  = 2'd1,
    ERR_EXTN_MATCH = 2'd2
  } err_e;

  // Parse phase, one-hot
  typedef enum logic [7:0] {
    PH_HEADER  = 8'b0000_0001,
    PH_MAGIC   = 8'b0000_0010,
    PH_EXTLEN  = 8'b0000_0100,
    PH_EXTN    = 8'b0000_1000,
    PH_PAYLEN  = 8'b0001_0000,
    PH_PAYLOAD = 8'b0010_0000,
    PH_DONE    = 8'b0100_0000,
    PH_HALT    = 8'b1000_0000
  } phase_e;

  // Configuration register set
  typedef struct packed {
    logic [9:0]  header_skip;
    logic [3:0]  magic_length;
    logic [63:0] magic_chars;
    logic        extn_check_enable;
    logic [2:0]  expected_extn_length;
    logic [31:0] expected_extn;
  } cfg_t;

  // Input item
  typedef struct packed {
    logic [7:0] image_byte;
    logic       start_of_image;
  } in_item_t;

  // Result item
  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    err_e       error_code;
    logic       last;
  } result_t;

endpackage
`default_nettype wire

@@ hw/rtl/lse_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lse_cfg_regs
// Configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
module lse_cfg_regs import lse_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wr_en_i,
  input  wire logic [2:0]  wr_index_i,
  input  wire logic [63:0] wr_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the register index
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_idx_e'(wr_index_i))
        CFG_HEADER_SKIP:   cfg_d.header_skip          = wr_data_i[9:0];
        CFG_MAGIC_LENGTH:  cfg_d.magic_length         = wr_data_i[3:0];
        CFG_MAGIC_CHARS:   cfg_d.magic_chars          = wr_data_i;
        CFG_EXTN_CHECK_EN: cfg_d.extn_check_enable    = wr_data_i[0];
        CFG_EXP_EXTN_LEN:  cfg_d.expected_extn_length = wr_data_i[2:0];
        CFG_EXP_EXTN:      cfg_d.expected_extn        = wr_data_i[31:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_skip          <= 10'd54;
      cfg_q.magic_length         <= 4'd2;
      cfg_q.magic_chars          <= '0;
      cfg_q.extn_check_enable    <= 1'b0;
      cfg_q.expected_extn_length <= 3'd4;
      cfg_q.expected_extn        <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ hw/rtl/lse_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lse_parser
// Frame parser: one image byte per cycle while accept_i is high; shifts in
// its LSB and steps the header / signature / extension / length / payload sequence.
// ----------------------------------------------------------------------------
module lse_parser import lse_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     accept_i,
  input  in_item_t      item_i,
  input  cfg_t          cfg_i,
  output logic          res_valid_o,
  output result_t       res_o
);

  phase_e                  phase_q, phase_d;
  logic [9:0]              hdr_cnt_q, hdr_cnt_d;
  logic [SIZE_FIELD_BITS-1:0] shift_q, shift_d;
  logic [BitCntW-1:0]      bit_cnt_q, bit_cnt_d;
  logic [2:0]              char_idx_q, char_idx_d;
  logic [2:0]              extn_len_q, extn_len_d;
  logic [SIZE_FIELD_BITS-1:0] pay_rem_q, pay_rem_d;

  logic [3:0]              magic_eff;
  logic                    res_valid;
  result_t                 res;

  // Signature length clamp
  assign magic_eff = (cfg_i.magic_length > 4'(MAX_MAGIC_CHARS)) ?
                     4'(MAX_MAGIC_CHARS) : cfg_i.magic_length;

  // Next state and result for the byte at the input
  always_comb begin
    logic                       skip;
    logic [SIZE_FIELD_BITS-1:0] shifted;
    logic [BitCntW-1:0]         cnt_inc;
    logic [SIZE_FIELD_BITS-1:0] n;
    logic [CHAR_BITS-1:0]       ch;
    logic [CHAR_BITS-1:0]       exp_ch;
    logic [3:0]                 idx_inc;

    phase_d    = phase_q;
    hdr_cnt_d  = hdr_cnt_q;
    shift_d    = shift_q;
    bit_cnt_d  = bit_cnt_q;
    char_idx_d = char_idx_q;
    extn_len_d = extn_len_q;
    pay_rem_d  = pay_rem_q;
    res_valid  = 1'b0;
    res        = '0;
    skip       = 1'b0;
    shifted    = '0;
    cnt_inc    = '0;
    n          = '0;
    ch         = '0;
    exp_ch     = '0;
    idx_inc    = '0;

    // Start mark clears parsing state
    if (item_i.start_of_image) begin
      phase_d    = PH_HEADER;
      hdr_cnt_d  = '0;
      shift_d    = '0;
      bit_cnt_d  = '0;
      char_idx_d = '0;
      extn_len_d = '0;
      pay_rem_d  = '0;
    end

    // Header skip
    if (phase_d == PH_HEADER) begin
      if (hdr_cnt_d < cfg_i.header_skip) begin
        hdr_cnt_d = hdr_cnt_d + 10'd1;
        skip      = 1'b1;
      end else begin
        phase_d = (magic_eff == 4'd0) ? PH_EXTLEN : PH_MAGIC;
      end
    end

    if (!skip && phase_d != PH_DONE && phase_d != PH_HALT) begin
      shifted   = {shift_d[SIZE_FIELD_BITS-2:0], item_i.image_byte[0]};
      cnt_inc   = bit_cnt_d + BitCntW'(1);
      shift_d   = shifted;
      bit_cnt_d = cnt_inc;
      ch        = shifted[CHAR_BITS-1:0];
      idx_inc   = {1'b0, char_idx_d} + 4'd1;

      case (phase_d)
        // Size fields
        PH_EXTLEN, PH_PAYLEN: begin
          if (cnt_inc == BitCntW'(SIZE_FIELD_BITS)) begin
            n         = shifted;
            shift_d   = '0;
            bit_cnt_d = '0;
            if (phase_d == PH_EXTLEN) begin
              if (n > SIZE_FIELD_BITS'(MAX_EXTN_CHARS)) begin
                phase_d        = PH_HALT;
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_EXTN_LONG;
                res.last       = 1'b1;
              end else begin
                extn_len_d = n[2:0];
                char_idx_d = '0;
                if (cfg_i.extn_check_enable &&
                    n != SIZE_FIELD_BITS'(cfg_i.expected_extn_length)) begin
                  phase_d        = PH_HALT;
                  res_valid      = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_EXTN_MATCH;
                  res.last       = 1'b1;
                end else begin
                  phase_d = (n == '0) ? PH_PAYLEN : PH_EXTN;
                end
              end
            end else begin
              pay_rem_d = n;
              if (n == '0) begin
                phase_d   = PH_DONE;
                res_valid = 1'b1;
                res.kind  = KIND_EMPTY;
                res.last  = 1'b1;
              end else begin
                phase_d = PH_PAYLOAD;
              end
            end
          end
        end

        // Signature characters
        PH_MAGIC: begin
          if (cnt_inc == BitCntW'(CHAR_BITS)) begin
            shift_d   = '0;
            bit_cnt_d = '0;
            exp_ch    = cfg_i.magic_chars[{char_idx_d, 3'b000} +: CHAR_BITS];
            if (ch != exp_ch) begin
              phase_d        = PH_HALT;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_MAGIC;
              res.last       = 1'b1;
            end else if (idx_inc >= magic_eff) begin
              char_idx_d = '0;
              phase_d    = PH_EXTLEN;
            end else begin
              char_idx_d = idx_inc[2:0];
            end
          end
        end

        // Extension characters: emit or compare
        PH_EXTN: begin
          if (cnt_inc == BitCntW'(CHAR_BITS)) begin
            shift_d   = '0;
            bit_cnt_d = '0;
            exp_ch    = char_idx_d[2] ? '0 :
                        cfg_i.expected_extn[{char_idx_d[1:0], 3'b000} +: CHAR_BITS];
            if (cfg_i.extn_check_enable && ch != exp_ch) begin
              phase_d        = PH_HALT;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_EXTN_MATCH;
              res.last       = 1'b1;
            end else begin
              if (!cfg_i.extn_check_enable) begin
                res_valid = 1'b1;
                res.kind  = KIND_EXTN_CHAR;
                res.value = ch;
              end
              if (idx_inc >= {1'b0, extn_len_d}) begin
                char_idx_d = '0;
                phase_d    = PH_PAYLEN;
              end else begin
                char_idx_d = idx_inc[2:0];
              end
            end
          end
        end

        // Payload bytes
        PH_PAYLOAD: begin
          if (cnt_inc == BitCntW'(CHAR_BITS)) begin
            shift_d   = '0;
            bit_cnt_d = '0;
            pay_rem_d = pay_rem_d - SIZE_FIELD_BITS'(1);
            res_valid = 1'b1;
            res.kind  = KIND_PAYLOAD;
            res.value = ch;
            res.last  = (pay_rem_q == SIZE_FIELD_BITS'(1));
            if (pay_rem_d == '0) begin
              phase_d = PH_DONE;
            end
          end
        end

        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  // State registers, advanced on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      hdr_cnt_q  <= '0;
      shift_q    <= '0;
      bit_cnt_q  <= '0;
      char_idx_q <= '0;
      extn_len_q <= '0;
      pay_rem_q  <= '0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      hdr_cnt_q  <= hdr_cnt_d;
      shift_q    <= shift_d;
      bit_cnt_q  <= bit_cnt_d;
      char_idx_q <= char_idx_d;
      extn_len_q <= extn_len_d;
      pay_rem_q  <= pay_rem_d;
    end
  end

  assign res_valid_o = accept_i && res_valid;
  assign res_o       = res;

endmodule
`default_nettype wire

@@ hw/rtl/lse_out_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lse_out_buf
// Result register with a skid stage behind it; stalls upstream only when
// the skid stage is occupied.
// ----------------------------------------------------------------------------
module lse_out_buf import lse_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  result_t   push_data_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output result_t   out_data_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop = out_valid_q && !out_stall_i;

  // Buffer control
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (out_valid_q && !pop) begin
      if (push_i) begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else begin
      out_valid_d = push_i;
      if (push_i) begin
        out_d = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

@@ hw/rtl/lsb_stego_stream_extractor_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsb_stego_stream_extractor_top
// Extracts a hidden frame from the LSBs of a cover image byte stream.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   in_item_t  (image byte, start mark)
//   out      output     out_valid_o / out_stall_i result_t   (kind, value, code, last)
//   cfg      input      cfg_valid_i / cfg_ready_o index 3b, data 64b
//
// One image byte is taken per cycle while in_stall_o is low; the parser
// state updates in that cycle and any result is registered at the same edge,
// in the output register or, behind a stalled one, in the skid stage.
// in_stall_o rises only when both the output register and its skid stage
// hold results; the input then waits until the sink drains one.
// Reset restores the register defaults and starts as if an image began.
// ----------------------------------------------------------------------------
module lsb_stego_stream_extractor_top import lse_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // image byte channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output result_t          out_data_o,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  cfg_t    cfg;
  logic    in_accept;
  logic    res_valid;
  result_t res;
  logic    buf_full;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && !buf_full;
  assign in_stall_o  = buf_full;

  // Configuration registers
  lse_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Frame parser
  lse_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .item_i      (in_data_i),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register and skid stage
  lse_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // Skid stage only fills behind an occupied result register
  a_stall_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty result register");

  // Stall only follows a stalled result
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without a stalled result");

  // Empty-frame and error results always close the frame
  a_last_on_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.kind == KIND_ERROR || out_data_o.kind == KIND_EMPTY))
      |-> (out_data_o.last && out_data_o.value == '0))
    else $error("end result without last flag or with nonzero value");
`endif

endmodule
`default_nettype wire
